// ===== rtl/core/pbl_pkg.sv =====
// shared types and constants for the particle boundary label and wrap block
// no dependencies; imported by every module in rtl/core
package pbl_pkg;

  localparam int unsigned CoordBits  = 32;
  localparam int unsigned OriginBits = 31;
  localparam int unsigned LengthBits = 30;
  localparam int unsigned StatusBits = 6;
  localparam int unsigned RegionBits = 5;
  localparam int unsigned NumAxes    = 3;
  localparam int unsigned PaddrBits  = 5;
  localparam int unsigned DataBits   = 32;
  localparam int unsigned RegIdxBits = PaddrBits - 2;

  // working width for exact compares and wrap sums before clamping
  localparam int unsigned ExtBits =
      ((CoordBits > OriginBits + 1) ? CoordBits : OriginBits + 1) + 2;

  localparam logic [StatusBits-1:0] StatusTracked = 6'd2;
  localparam logic [StatusBits-1:0] TrackedBase   = 6'd28;
  localparam logic [StatusBits-1:0] PlainBase     = 6'd2;

  localparam logic [RegionBits-1:0] RegionInside = 5'd0;
  localparam logic [RegionBits-1:0] RegionMax    = 5'd26;

  localparam logic [LengthBits-1:0] LengthReset = 30'd65536;

  typedef enum logic [1:0] {
    AxisInside = 2'd0,
    AxisLow    = 2'd1,
    AxisHigh   = 2'd2
  } pbl_axis_e;

  typedef enum logic [RegIdxBits-1:0] {
    RegOriginX = 3'd0,
    RegOriginY = 3'd1,
    RegOriginZ = 3'd2,
    RegLengthX = 3'd3,
    RegLengthY = 3'd4,
    RegLengthZ = 3'd5
  } pbl_reg_e;

  typedef struct packed {
    logic [StatusBits-1:0]       old_status;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
  } pbl_in_t;

  typedef struct packed {
    logic [StatusBits-1:0]       out_status;
    logic [RegionBits-1:0]       region_index;
    logic signed [CoordBits-1:0] wrapped_x;
    logic signed [CoordBits-1:0] wrapped_y;
    logic signed [CoordBits-1:0] wrapped_z;
  } pbl_out_t;

  typedef struct packed {
    logic [NumAxes-1:0][OriginBits-1:0] origin;
    logic [NumAxes-1:0][LengthBits-1:0] length;
  } pbl_cfg_t;

endpackage

// ===== rtl/core/pbl_regs.sv =====
// box configuration registers behind the apb-style port
// depends on pbl_pkg
module pbl_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pbl_pkg::PaddrBits-1:0]  paddr,
  input  logic [pbl_pkg::DataBits-1:0]   pwdata,
  output logic [pbl_pkg::DataBits-1:0]   prdata,
  output logic                           pready,
  output pbl_pkg::pbl_cfg_t              cfg_o
);
  import pbl_pkg::*;

  logic [NumAxes-1:0][OriginBits-1:0] origin_q;
  logic [NumAxes-1:0][LengthBits-1:0] length_q;
  logic                               wr_en;
  pbl_reg_e                           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = pbl_reg_e'(paddr[PaddrBits-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      length_q <= {NumAxes{LengthReset}};
    end else if (wr_en) begin
      unique case (reg_idx)
        RegOriginX: origin_q[0] <= pwdata[OriginBits-1:0];
        RegOriginY: origin_q[1] <= pwdata[OriginBits-1:0];
        RegOriginZ: origin_q[2] <= pwdata[OriginBits-1:0];
        RegLengthX: length_q[0] <= pwdata[LengthBits-1:0];
        RegLengthY: length_q[1] <= pwdata[LengthBits-1:0];
        RegLengthZ: length_q[2] <= pwdata[LengthBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegOriginX: prdata = DataBits'($signed(origin_q[0]));
      RegOriginY: prdata = DataBits'($signed(origin_q[1]));
      RegOriginZ: prdata = DataBits'($signed(origin_q[2]));
      RegLengthX: prdata = DataBits'(length_q[0]);
      RegLengthY: prdata = DataBits'(length_q[1]);
      RegLengthZ: prdata = DataBits'(length_q[2]);
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.origin = origin_q;
  assign cfg_o.length = length_q;

endmodule

// ===== rtl/core/pbl_axis.sv =====
// one axis: strict box compare and saturating periodic wrap
// depends on pbl_pkg
module pbl_axis (
  input  logic signed [pbl_pkg::CoordBits-1:0]  pos_i,
  input  logic signed [pbl_pkg::OriginBits-1:0] origin_i,
  input  logic [pbl_pkg::LengthBits-1:0]        length_i,
  output pbl_pkg::pbl_axis_e                    code_o,
  output logic signed [pbl_pkg::CoordBits-1:0]  wrapped_o
);
  import pbl_pkg::*;

  localparam logic signed [ExtBits-1:0] CMaxExt =
      {{(ExtBits-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}};
  localparam logic signed [ExtBits-1:0] CMinExt = ~CMaxExt;

  logic signed [ExtBits-1:0] p_ext;
  logic signed [ExtBits-1:0] lo_ext;
  logic signed [ExtBits-1:0] len_ext;
  logic signed [ExtBits-1:0] hi_ext;
  logic signed [ExtBits-1:0] sum_ext;
  logic signed [ExtBits-1:0] sel_ext;

  assign p_ext   = ExtBits'(pos_i);
  assign lo_ext  = ExtBits'(origin_i);
  assign len_ext = $signed(ExtBits'(length_i));
  assign hi_ext  = lo_ext + len_ext;

  always_comb begin
    if (p_ext < lo_ext) begin
      code_o  = AxisLow;
      sum_ext = p_ext + len_ext;
    end else if (p_ext > hi_ext) begin
      code_o  = AxisHigh;
      sum_ext = p_ext - len_ext;
    end else begin
      code_o  = AxisInside;
      sum_ext = p_ext;
    end
  end

  // clamp to the coordinate range
  always_comb begin
    priority if (sum_ext > CMaxExt) begin
      sel_ext = CMaxExt;
    end else if (sum_ext < CMinExt) begin
      sel_ext = CMinExt;
    end else begin
      sel_ext = sum_ext;
    end
  end

  assign wrapped_o = sel_ext[CoordBits-1:0];

endmodule

// ===== rtl/core/pbl_label.sv =====
// region index and status relabel from the three axis codes
// depends on pbl_pkg
module pbl_label (
  input  logic [pbl_pkg::StatusBits-1:0] old_status_i,
  input  pbl_pkg::pbl_axis_e             code_x_i,
  input  pbl_pkg::pbl_axis_e             code_y_i,
  input  pbl_pkg::pbl_axis_e             code_z_i,
  output logic [pbl_pkg::StatusBits-1:0] out_status_o,
  output logic [pbl_pkg::RegionBits-1:0] region_o
);
  import pbl_pkg::*;

  logic [1:0] cx;
  logic [1:0] cy;
  logic [1:0] cz;

  assign cx = code_x_i;
  assign cy = code_y_i;
  assign cz = code_z_i;

  // 9x + 3y + z
  assign region_o = RegionBits'({cx, 3'b000}) + RegionBits'(cx)
                  + RegionBits'({cy, 1'b0}) + RegionBits'(cy)
                  + RegionBits'(cz);

  always_comb begin
    priority if (region_o == RegionInside) begin
      out_status_o = old_status_i;
    end else if (old_status_i == StatusTracked) begin
      out_status_o = TrackedBase + StatusBits'(region_o);
    end else begin
      out_status_o = PlainBase + StatusBits'(region_o);
    end
  end

endmodule

// ===== rtl/core/particle_boundary_label_wrap.sv =====
// particle boundary label and wrap, top level: input register, label/wrap logic, result register
// beats pass input register then result register; one beat per cycle while out_stall_i is low
// the input register, if empty, takes a beat while a stalled result waits in the result register
// rst_ni clears both valid flags and loads origin 0 and length 1.0 on each axis
// depends on pbl_pkg, pbl_regs, pbl_axis, pbl_label
module particle_boundary_label_wrap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pbl_pkg::pbl_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pbl_pkg::pbl_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbl_pkg::PaddrBits-1:0] paddr,
  input  logic [pbl_pkg::DataBits-1:0]  pwdata,
  output logic [pbl_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);
  import pbl_pkg::*;

  pbl_cfg_t  cfg;
  pbl_in_t   in_q;
  pbl_out_t  out_q;
  pbl_out_t  out_d;
  logic      s1_valid_q;
  logic      s2_valid_q;
  logic      s1_adv;
  logic      s2_adv;
  pbl_axis_e code_x;
  pbl_axis_e code_y;
  pbl_axis_e code_z;

  pbl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign s2_adv     = !s2_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (s2_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  pbl_axis u_axis_x (
    .pos_i     (in_q.pos_x),
    .origin_i  (cfg.origin[0]),
    .length_i  (cfg.length[0]),
    .code_o    (code_x),
    .wrapped_o (out_d.wrapped_x)
  );

  pbl_axis u_axis_y (
    .pos_i     (in_q.pos_y),
    .origin_i  (cfg.origin[1]),
    .length_i  (cfg.length[1]),
    .code_o    (code_y),
    .wrapped_o (out_d.wrapped_y)
  );

  pbl_axis u_axis_z (
    .pos_i     (in_q.pos_z),
    .origin_i  (cfg.origin[2]),
    .length_i  (cfg.length[2]),
    .code_o    (code_z),
    .wrapped_o (out_d.wrapped_z)
  );

  pbl_label u_label (
    .old_status_i (in_q.old_status),
    .code_x_i     (code_x),
    .code_y_i     (code_y),
    .code_z_i     (code_z),
    .out_status_o (out_d.out_status),
    .region_o     (out_d.region_index)
  );

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s2_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.region_index <= RegionMax))
    else $error("region index out of range");

  a_relabel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.region_index != RegionInside)) |->
      ((out_data_o.out_status > PlainBase) &&
       (out_data_o.out_status <= TrackedBase + StatusBits'(RegionMax))))
    else $error("relabeled status outside label codes");

  a_result_follows_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_adv) |=> s2_valid_q)
    else $error("item lost between input and result register");
`endif

endmodule
